>>> rtl/substring_delete_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the substring delete filter RTL
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_DELETE_FILTER_CORE_MACROS_SVH
`define SUBSTRING_DELETE_FILTER_CORE_MACROS_SVH

// Clocked check, masked while reset is held.
`define SDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that is live during reset as well.
`define SDF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the substring delete filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  localparam int MAX_PATTERN_DEF = 16;  // deepest window the design supports
  localparam int LEN_W           = 5;   // pattern_length register width
  localparam int PAT_W           = 64;  // width of each pattern register, eight pattern bytes
  localparam int BYTE_W          = 8;
  localparam int CFG_IDX_W       = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,   // write input byte into window, bump fill
    OP_POP,      // oldest window byte to output, shift window down
    OP_PASS,     // input byte straight to output (pattern length zero)
    OP_MARK,     // end marker result, no byte
    OP_CLEAR     // drop whole window (pattern matched)
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   done;   // string_done for the result loaded this cycle
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;  // active pattern length is zero
    logic full;      // window fill equals pattern length
    logic match;     // window equals pattern
    logic fill_one;  // exactly one pending byte
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/sdf_datapath.sv
// ----------------------------------------------------------------------------
// sdf_datapath
// Window shift register, pattern registers, parallel compare, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_datapath #(
  parameter int MAX_PATTERN = sdf_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [sdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sdf_pkg::PAT_W-1:0]      cfg_data,
  // input byte
  input  wire logic [sdf_pkg::BYTE_W-1:0]     in_byte,
  // control
  input  wire sdf_pkg::dp_cmd_t               cmd,
  output sdf_pkg::dp_stat_t                   stat,
  // result
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [sdf_pkg::BYTE_W-1:0]          out_tdata,   // [7:0] kept_byte
  output logic                                out_tuser,   // [0] byte_present
  output logic                                out_tlast    // string_done
);

  localparam int DEPTH  = MAX_PATTERN;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [sdf_pkg::LEN_W-1:0] LEN_MAX = sdf_pkg::LEN_W'(DEPTH);

  logic [sdf_pkg::LEN_W-1:0]  len_r;
  logic [sdf_pkg::PAT_W-1:0]  pat_lo_r, pat_hi_r;
  logic [2*sdf_pkg::PAT_W-1:0] pat;
  logic [sdf_pkg::LEN_W-1:0]  len_act;

  logic [sdf_pkg::BYTE_W-1:0] win_r   [DEPTH];
  logic [sdf_pkg::BYTE_W-1:0] win_nxt [DEPTH];
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [IDX_W-1:0]           app_idx;

  logic                       out_valid_r, out_valid_nxt;
  logic [sdf_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                       out_pres_r, out_pres_nxt;
  logic                       out_done_r, out_done_nxt;
  logic                       load_out;

  logic [DEPTH-1:0]           cmp_ok;

  assign pat     = {pat_hi_r, pat_lo_r};
  assign len_act = (len_r > LEN_MAX) ? LEN_MAX : len_r;

  // a stale window after a length change starts over at entry zero
  assign app_idx = (sdf_pkg::LEN_W'(fill_r) >= len_act) ? '0 : fill_r[IDX_W-1:0];

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      cmp_ok[k] = (sdf_pkg::LEN_W'(k) >= len_act) ||
                  (win_r[k] == pat[k*sdf_pkg::BYTE_W +: sdf_pkg::BYTE_W]);
    end
  end

  assign stat.len_zero = (len_act == '0);
  assign stat.full     = (sdf_pkg::LEN_W'(fill_r) == len_act);
  assign stat.match    = &cmp_ok;
  assign stat.fill_one = (fill_r == FILL_W'(1));
  assign stat.out_free = !out_valid_r || out_tready;

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    unique case (cmd.op)
      sdf_pkg::OP_APPEND: begin
        win_nxt[app_idx] = in_byte;
        fill_nxt         = FILL_W'(app_idx) + FILL_W'(1);
      end
      sdf_pkg::OP_POP: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        fill_nxt = fill_r - FILL_W'(1);
      end
      sdf_pkg::OP_CLEAR: fill_nxt = '0;
      sdf_pkg::OP_NONE, sdf_pkg::OP_PASS, sdf_pkg::OP_MARK: ;
      default: ;
    endcase
    if (cfg_we && cfg_index == sdf_pkg::REG_LENGTH) begin
      fill_nxt = '0;
    end
  end

  always_comb begin
    load_out     = 1'b1;
    out_byte_nxt = out_byte_r;
    out_pres_nxt = out_pres_r;
    out_done_nxt = out_done_r;
    unique case (cmd.op)
      sdf_pkg::OP_POP: begin
        out_byte_nxt = win_r[0];
        out_pres_nxt = 1'b1;
      end
      sdf_pkg::OP_PASS: begin
        out_byte_nxt = in_byte;
        out_pres_nxt = 1'b1;
      end
      sdf_pkg::OP_MARK: begin
        out_byte_nxt = '0;
        out_pres_nxt = 1'b0;
      end
      default: load_out = 1'b0;
    endcase
    if (load_out) begin
      out_done_nxt = cmd.done;
    end
    out_valid_nxt = load_out || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          sdf_pkg::REG_LENGTH:   len_r    <= cfg_data[sdf_pkg::LEN_W-1:0];
          sdf_pkg::REG_PAT_LOW:  pat_lo_r <= cfg_data;
          sdf_pkg::REG_PAT_HIGH: pat_hi_r <= cfg_data;
          default: ;  // unknown index ignored
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    out_byte_r <= out_byte_nxt;
    out_pres_r <= out_pres_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_pres_r;
  assign out_tlast  = out_done_r;

endmodule

`default_nettype wire

>>> rtl/sdf_ctrl.sv
// ----------------------------------------------------------------------------
// sdf_ctrl
// Per-item sequencer: pass-through, append, compare, flush and end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_last,
  input  wire sdf_pkg::dp_stat_t stat,
  output sdf_pkg::dp_cmd_t       cmd
);

  `include "substring_delete_filter_core_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FLUSH,
    S_MARK
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   in_fire;

  assign in_tready = (state_r == S_IDLE) && (!stat.len_zero || stat.out_free);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd.op    = sdf_pkg::OP_NONE;
    cmd.done  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (stat.len_zero) begin
            cmd.op   = sdf_pkg::OP_PASS;
            cmd.done = in_last;
          end else begin
            cmd.op    = sdf_pkg::OP_APPEND;
            last_nxt  = in_last;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        priority if (stat.full && stat.match) begin
          cmd.op    = sdf_pkg::OP_CLEAR;
          state_nxt = last_r ? S_MARK : S_IDLE;
        end else if (stat.full) begin
          if (stat.out_free) begin
            cmd.op   = sdf_pkg::OP_POP;
            // a one-byte pattern leaves nothing behind the popped byte
            cmd.done = last_r && stat.fill_one;
            state_nxt = (last_r && !stat.fill_one) ? S_FLUSH : S_IDLE;
          end
        end else begin
          state_nxt = last_r ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.op   = sdf_pkg::OP_POP;
          cmd.done = stat.fill_one;
          if (stat.fill_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MARK: begin
        if (stat.out_free) begin
          cmd.op    = sdf_pkg::OP_MARK;
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  `SDF_ASSERT(a_load_needs_room, ((cmd.op == sdf_pkg::OP_POP) || (cmd.op == sdf_pkg::OP_PASS) || (cmd.op == sdf_pkg::OP_MARK)) |-> stat.out_free, "result loaded into a busy output register")
  `SDF_ASSERT(a_append_then_check, (in_fire && !stat.len_zero) |=> (state_r == S_CHECK), "appended byte not followed by compare")
  `SDF_ASSERT(a_mark_only_at_end, (cmd.op == sdf_pkg::OP_MARK) |-> (last_r && cmd.done), "end marker outside the end of a string")
  `SDF_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE), "controller not idle after reset")

endmodule

`default_nettype wire

>>> rtl/substring_delete_filter_core.sv
// ----------------------------------------------------------------------------
// substring_delete_filter_core
// Byte stream filter that removes every non-overlapping occurrence of a
// configured pattern, found greedily from left to right.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / data         | tuser        | tlast
//  in_     | slave     | [7:0] text_byte      | -            | string_end
//  out_    | master    | [7:0] kept_byte      | byte_present | string_done
//  cfg_    | slave     | cfg_index, cfg_data  | -            | -
//
// Pattern length zero: one byte per cycle while out_ is free, straight into
// the output register. Otherwise each byte is appended, then the window is
// compared; the final byte of a string adds a pop per byte left in the window,
// or the end marker. The output register is the only result slot.
// Reset is synchronous and clears control and configuration; no clearing pass.
// A stalled out_ side holds the sequencer where it wants to load a result.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_delete_filter_core #(
  parameter int MAX_PATTERN = sdf_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sdf_pkg::BYTE_W-1:0]    in_tdata,    // [7:0] text_byte
  input  wire logic                          in_tlast,    // string_end
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [sdf_pkg::BYTE_W-1:0]         out_tdata,   // [7:0] kept_byte
  output logic                               out_tuser,   // [0] byte_present
  output logic                               out_tlast,   // string_done
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sdf_pkg::PAT_W-1:0]     cfg_data
);

  sdf_pkg::dp_cmd_t  cmd;
  sdf_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_last   (in_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  sdf_datapath #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for substring_delete_filter_core
// Streams byte strings through the filter and checks every result against a
// behavioral model of greedy, non-overlapping pattern deletion. Covers
// pass-through, zero bytes, full deletion with end markers, oversized lengths,
// pattern updates in mid-string and random pattern-rich strings under stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // not mapped, writes ignored
  localparam int RANDOM_ITEMS = 430;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [BYTE_W-1:0] kept;
    logic              present;
    logic              done;
  } kept_result_t;

  typedef logic [BYTE_W-1:0] text_q_t[$];

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata;   // [7:0] text_byte
  logic                 in_tlast;   // string_end
  logic                 out_tvalid;
  logic                 out_tready;
  logic [BYTE_W-1:0]    out_tdata;  // [7:0] kept_byte
  logic                 out_tuser;  // [0] byte_present
  logic                 out_tlast;  // string_done
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_data;

  // filter model state
  logic [LEN_W-1:0]  pat_len;
  logic [PAT_W-1:0]  pat_lo;
  logic [PAT_W-1:0]  pat_hi;
  logic [BYTE_W-1:0] win_bytes [MAX_PATTERN_DEF];
  int                win_fill;

  kept_result_t pending_kept[$];
  int           errors = 0;
  int           cycle_count = 0;
  bit           steady_flow = 1'b0;

  substring_delete_filter_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL substring_delete_filter_core");
      $finish;
    end
  end

  // mostly short idles, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic bit window_hit(int span);
    logic [2*PAT_W-1:0] pat_bits;
    int k;
    pat_bits = {pat_hi, pat_lo};
    for (k = 0; k < span; k++)
      if (win_bytes[k] != pat_bits[8*k +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_kept_bytes(logic [BYTE_W-1:0] value, logic is_end);
    kept_result_t step_res[$];
    int span;
    int k;
    span = (int'(pat_len) > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
    if (span == 0) begin
      pending_kept.push_back('{kept: value, present: 1'b1, done: is_end});
      return;
    end
    if (win_fill >= span) win_fill = 0;
    win_bytes[win_fill] = value;
    win_fill++;
    if (win_fill == span) begin
      if (window_hit(span)) begin
        win_fill = 0;
      end else begin
        step_res.push_back('{kept: win_bytes[0], present: 1'b1, done: 1'b0});
        for (k = 0; k < span - 1; k++) win_bytes[k] = win_bytes[k+1];
        win_fill = span - 1;
      end
    end
    if (is_end) begin
      for (k = 0; k < win_fill; k++)
        step_res.push_back('{kept: win_bytes[k], present: 1'b1, done: 1'b0});
      win_fill = 0;
      // nothing left to send: close the string with a bare marker
      if (step_res.size() == 0)
        step_res.push_back('{kept: '0, present: 1'b0, done: 1'b1});
      else
        step_res[step_res.size()-1].done = 1'b1;
    end
    foreach (step_res[k]) pending_kept.push_back(step_res[k]);
  endfunction

  task automatic send_text(input logic [BYTE_W-1:0] value, input logic is_end);
    int gap;
    gap = steady_flow ? 0 : idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= is_end;
    do @(posedge clk); while (!in_tready);
    predict_kept_bytes(value, is_end);
  endtask

  task automatic send_string(input text_q_t str, input bit close_it = 1'b1);
    int k;
    for (k = 0; k < str.size(); k++)
      send_text(str[k], close_it && (k == str.size() - 1));
  endtask

  // input side quiet, every result delivered, then let any silent work finish
  task automatic drain_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_kept.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LENGTH: begin
        pat_len  = value[LEN_W-1:0];
        win_fill = 0;
      end
      REG_PAT_LOW:  pat_lo = value;
      REG_PAT_HIGH: pat_hi = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    kept_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_kept.size() == 0) begin
        $error("unexpected result: kept_byte=%0h byte_present=%0b string_done=%0b",
               out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = pending_kept.pop_front();
        if (out_tdata !== want.kept) begin
          $error("kept_byte: expected %0h, got %0h", want.kept, out_tdata);
          errors++;
        end
        if (out_tuser !== want.present) begin
          $error("byte_present: expected %0b, got %0b", want.present, out_tuser);
          errors++;
        end
        if (out_tlast !== want.done) begin
          $error("string_done: expected %0b, got %0b", want.done, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin : out_side
    int run;
    out_tready = 1'b0;
    forever begin
      if (steady_flow) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        run = $urandom_range(1, 6);
        repeat (run) begin
          @(negedge clk);
          out_tready <= 1'b1;
        end
        run = idle_cycles();
        repeat (run) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
    end
  end

  // reset config has length zero; an unmapped write must not disturb it
  task automatic test_pass_through();
    send_string('{8'h00, 8'hFF}, 1'b0);
    drain_block();
    write_reg(REG_SPARE, {PAT_W{1'b1}});
    send_string('{8'hA5, 8'h5A});
  endtask

  task automatic test_zero_byte_pattern();
    drain_block();
    write_reg(REG_PAT_LOW, 64'h0000_0000_0000_FF00);
    write_reg(REG_PAT_HIGH, {PAT_W{1'b1}});
    write_reg(REG_LENGTH, 64'd2);
    send_string('{8'h00, 8'hFF, 8'h00, 8'hFF});        // everything deleted
    send_string('{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF}); // ends on a match
  endtask

  task automatic test_single_byte_pattern();
    drain_block();
    write_reg(REG_PAT_LOW, 64'h0000_0000_0000_00FF);
    write_reg(REG_LENGTH, 64'd1);
    send_string('{8'hFF});
    send_string('{8'hFF, 8'h00});
  endtask

  // lengths above the window depth clamp to full depth
  task automatic test_oversize_length();
    drain_block();
    write_reg(REG_LENGTH, {{(PAT_W-LEN_W){1'b1}}, 5'd31});
    send_string('{8'h01, 8'h80, 8'h7F});
  endtask

  task automatic test_config_mid_string();
    drain_block();
    write_reg(REG_PAT_LOW, 64'h0000_0000_0000_6261);
    write_reg(REG_LENGTH, 64'd2);
    send_string('{8'h61}, 1'b0);
    drain_block();
    write_reg(REG_PAT_LOW, 64'h0000_0000_0000_6361);  // pending byte stays in the window
    send_string('{8'h63});
    send_string('{8'h61}, 1'b0);
    drain_block();
    write_reg(REG_LENGTH, 64'd2);                      // pending byte is dropped
    send_string('{8'h63});
  endtask

  task automatic test_random_strings();
    logic [BYTE_W-1:0]  pat [MAX_PATTERN_DEF];
    logic [2*PAT_W-1:0] pbits;
    logic [PAT_W-1:0]   len_word;
    text_q_t            str;
    int plen, span, n_str, n_seg, kind, cnt, k, j, sent;
    bit alpha;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_block();
      kind = $urandom_range(0, 9);
      if (kind == 0)      plen = 0;
      else if (kind == 1) plen = $urandom_range(17, 31);
      else if (kind <= 3) plen = MAX_PATTERN_DEF;
      else if (kind == 4) plen = 1;
      else                plen = $urandom_range(2, 6);
      span = (plen > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : plen;
      // a two-letter alphabet gives overlapping near-matches
      alpha = $urandom_range(0, 1);
      for (k = 0; k < MAX_PATTERN_DEF; k++) begin
        pat[k] = alpha ? ($urandom_range(0, 1) ? 8'h41 : 8'h42) : BYTE_W'($urandom);
        pbits[8*k +: 8] = pat[k];
      end
      write_reg(REG_PAT_LOW, pbits[PAT_W-1:0]);
      write_reg(REG_PAT_HIGH, pbits[2*PAT_W-1:PAT_W]);
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = plen[LEN_W-1:0];
      write_reg(REG_LENGTH, len_word);
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
      steady_flow = ($urandom_range(0, 3) == 0);

      n_str = $urandom_range(1, 4);
      repeat (n_str) begin
        str = {};
        n_seg = (span >= 8) ? $urandom_range(1, 3) : $urandom_range(1, 6);
        repeat (n_seg) begin
          kind = (span == 0) ? 9 : $urandom_range(0, 9);
          if (kind <= 3) begin
            for (j = 0; j < span; j++) str.push_back(pat[j]);
            // broken copy: one bit flipped somewhere
            if (kind == 3) begin
              j = str.size() - 1 - $urandom_range(0, span - 1);
              str[j] = str[j] ^ (8'h01 << $urandom_range(0, 7));
            end
          end else if (kind <= 5) begin
            cnt = (span > 1) ? $urandom_range(1, span - 1) : 1;
            for (j = 0; j < cnt; j++) str.push_back(pat[j]);
          end else if (kind <= 7) begin
            str.push_back(pat[$urandom_range(0, span - 1)]);
          end else begin
            cnt = $urandom_range(1, 3);
            repeat (cnt) str.push_back(BYTE_W'($urandom));
          end
        end
        send_string(str);
        sent += str.size();
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pat_len   = '0;
    pat_lo    = '0;
    pat_hi    = '0;
    win_fill  = 0;
    foreach (win_bytes[k]) win_bytes[k] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_pass_through();
    test_zero_byte_pattern();
    test_single_byte_pattern();
    test_oversize_length();
    test_config_mid_string();
    test_random_strings();

    drain_block();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("PASS substring_delete_filter_core");
    else
      $display("FAIL substring_delete_filter_core");
    $finish;
  end

endmodule

`default_nettype wire
